// ===== rtl/core/boundary_tag_heap_allocator_defines.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BTH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked out of reset.
`define BTH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ===== rtl/core/bth_pkg.sv =====
// Constants, types and codes of the boundary-tag heap allocator.
package bth_pkg;
    localparam int HEAP_BYTES     = 131072;
    localparam int HEADER_BYTES   = 32;
    localparam int MIN_FREE_BYTES = 8;
    localparam int UNITS          = HEAP_BYTES / HEADER_BYTES;
    localparam int UW             = $clog2(UNITS);
    localparam int LW             = UW + 1;
    localparam int AW             = 17;
    localparam int RW             = 18;
    localparam int HDR_SH         = $clog2(HEADER_BYTES);
    localparam int TAKE_LIM       = (HEADER_BYTES + MIN_FREE_BYTES + HEADER_BYTES - 1)
                                    / HEADER_BYTES;
    localparam logic [LW-1:0] LIST_END = LW'(UNITS);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    typedef struct packed {
        logic          used;
        logic [UW-1:0] size;
        logic [UW-1:0] lns;
        logic [LW-1:0] prev;
        logic [LW-1:0] next;
    } t_word;

    typedef struct packed {
        logic sub;
        logic cin;
    } t_alu_ctl;
endpackage

// ===== rtl/core/bth_mem.sv =====
// Heap tag memory: one word of boundary tags and free-list links per unit.
module bth_mem (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [bth_pkg::UW-1:0] i_waddr,
    input  bth_pkg::t_word         i_wdata,
    input  logic [bth_pkg::UW-1:0] i_raddr,
    output bth_pkg::t_word         o_rdata
);
    import bth_pkg::*;

    t_word r_mem [UNITS];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/bth_alu.sv =====
// Shared adder/subtractor used by the sequencer for unit arithmetic.
module bth_alu (
    input  bth_pkg::t_alu_ctl      i_ctl,
    input  logic [bth_pkg::LW-1:0] i_a,
    input  logic [bth_pkg::LW-1:0] i_b,
    output logic [bth_pkg::LW-1:0] o_sum
);
    import bth_pkg::*;

    logic [LW-1:0] b_op;

    assign b_op  = i_ctl.sub ? ~i_b : i_b;
    assign o_sum = i_a + b_op + LW'(i_ctl.cin);
endmodule

// ===== rtl/core/boundary_tag_heap_allocator.sv =====
// Top level: sequencer of the boundary-tag heap allocator.
//
//  channel   direction  signals                                     handshake
//  request   in         i_op, i_request_bytes, i_block_addr         start / busy
//  result    out        o_status, o_payload_addr                    o_valid strobe
//  config    in         i_cfg_data (fit policy)                     i_cfg_we
//
// An allocate walks the free list one entry at a time, as the tag memory has
// a single read port. A free reads the block and its neighbours before it
// writes, or ends early when its address is rejected.
// After reset a clearing pass sweeps all 4096 words of the tag memory; busy is
// high throughout. The result strobe lasts one cycle and cannot be stalled.
module boundary_tag_heap_allocator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_op,
    input  logic [bth_pkg::RW-1:0] i_request_bytes,
    input  logic [bth_pkg::AW-1:0] i_block_addr,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [bth_pkg::AW-1:0] o_payload_addr,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_data
);
    import bth_pkg::*;
    `include "boundary_tag_heap_allocator_defines.svh"

    typedef enum logic [18:0] {
        S_CLR  = 19'h00001,
        S_IDLE = 19'h00002,
        S_ARD  = 19'h00004,
        S_ACHK = 19'h00008,
        S_ADEC = 19'h00010,
        S_FRDU = 19'h00020,
        S_FCHK = 19'h00040,
        S_FRDL = 19'h00080,
        S_FRDR = 19'h00100,
        S_FDEC = 19'h00200,
        S_WR1  = 19'h00400,
        S_WR2  = 19'h00800,
        S_LN   = 19'h01000,
        S_LNW  = 19'h02000,
        S_LP   = 19'h04000,
        S_LPW  = 19'h08000,
        S_TG   = 19'h10000,
        S_TGW  = 19'h20000,
        S_DONE = 19'h40000
    } t_state;

    t_state r_state, n_state;
    logic [UW-1:0] r_clr, n_clr;
    logic [1:0]    r_fit;
    logic [LW-1:0] r_first, n_first, r_last, n_last;
    logic [LW-1:0] r_need, n_need, r_cur, n_cur, r_found, n_found;
    t_word         r_pw, n_pw, r_uw, n_uw, r_lw, n_lw;
    logic [UW-1:0] r_u, n_u, r_left, n_left;
    logic          r_hasl, n_hasl;
    logic [LW-1:0] r_r, n_r;
    logic [UW-1:0] r_a1, n_a1, r_a2, n_a2;
    t_word         r_w1, n_w1, r_w2, n_w2;
    logic          r_do2, n_do2, r_don, n_don, r_dop, n_dop, r_dot, n_dot;
    logic [LW-1:0] r_na, n_na, r_nv, n_nv, r_pa, n_pa, r_pv, n_pv, r_ta, n_ta;
    logic [UW-1:0] r_tv, n_tv;
    logic [1:0]    r_status, n_status;
    logic [AW-1:0] r_paddr, n_paddr;

    t_word         rdata, wdata;
    logic          we;
    logic [UW-1:0] waddr, raddr;
    t_alu_ctl      alu_ctl;
    logic [LW-1:0] alu_a, alu_b, alu_sum;

    logic [RW:0]          req_n;
    logic [UW-1:0]        rem, unit_q, ns;
    logic [LW-1:0]        out_unit;
    logic [LW+HDR_SH-1:0] addr_wide;
    logic                 fit, better, lfree, rfree;
    logic [LW-1:0]        pl1;

    bth_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bth_alu u_alu (
        .i_ctl (alu_ctl),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum)
    );

    // The shared adder forms the right neighbour on a free and the remainder on an allocate.
    always_comb begin
        alu_ctl = '{sub: 1'b0, cin: 1'b1};
        alu_a   = LW'(r_u);
        alu_b   = LW'(rdata.size);
        if (r_state == S_ADEC) begin
            alu_ctl = '{sub: 1'b1, cin: 1'b1};
            alu_a   = LW'(r_pw.size);
            alu_b   = r_need;
        end
    end

    always_comb begin
        case (r_state)
            S_ARD:   raddr = r_cur[UW-1:0];
            S_FRDU:  raddr = r_u;
            S_FRDL:  raddr = r_left;
            S_FRDR:  raddr = r_r[UW-1:0];
            S_LN:    raddr = r_na[UW-1:0];
            S_LP:    raddr = r_pa[UW-1:0];
            S_TG:    raddr = r_ta[UW-1:0];
            default: raddr = '0;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_a1;
        wdata = r_w1;
        case (r_state)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                if (r_clr == '0) begin
                    wdata = '{used: 1'b0, size: UW'(UNITS - 1), lns: '0,
                              prev: LIST_END, next: LIST_END};
                end
            end
            S_WR1: begin
                we = 1'b1;
            end
            S_WR2: begin
                we    = 1'b1;
                waddr = r_a2;
                wdata = r_w2;
            end
            S_LNW: begin
                we         = 1'b1;
                waddr      = r_na[UW-1:0];
                wdata      = rdata;
                wdata.next = r_nv;
            end
            S_LPW: begin
                we         = 1'b1;
                waddr      = r_pa[UW-1:0];
                wdata      = rdata;
                wdata.prev = r_pv;
            end
            S_TGW: begin
                we        = rdata.used;
                waddr     = r_ta[UW-1:0];
                wdata     = rdata;
                wdata.lns = r_tv;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;  n_clr = r_clr;     n_first = r_first; n_last = r_last;
        n_need = r_need;    n_cur = r_cur;     n_found = r_found; n_pw = r_pw;
        n_uw = r_uw;        n_lw = r_lw;       n_u = r_u;         n_left = r_left;
        n_hasl = r_hasl;    n_r = r_r;         n_a1 = r_a1;       n_a2 = r_a2;
        n_w1 = r_w1;        n_w2 = r_w2;       n_do2 = r_do2;     n_don = r_don;
        n_dop = r_dop;      n_dot = r_dot;     n_na = r_na;       n_nv = r_nv;
        n_pa = r_pa;        n_pv = r_pv;       n_ta = r_ta;       n_tv = r_tv;
        n_status = r_status; n_paddr = r_paddr;

        req_n     = (i_request_bytes == '0) ? (RW + 1)'(1) : (RW + 1)'(i_request_bytes);
        fit       = r_need <= LW'(rdata.size);
        better    = (r_fit == FIT_BEST) ? (rdata.size < r_pw.size) : (rdata.size > r_pw.size);
        rem       = alu_sum[UW-1:0];
        unit_q    = r_found[UW-1:0] + rem;
        out_unit  = '0;
        addr_wide = '0;
        pl1       = LW'(rdata.lns) + LW'(1);
        lfree     = r_hasl && !r_lw.used;
        rfree     = !r_r[UW] && !rdata.used;
        ns        = '0;

        case (r_state)
            S_CLR: begin
                n_clr = r_clr + UW'(1);
                if (r_clr == UW'(UNITS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_op == OP_ALLOC) begin
                        n_need  = LW'((req_n + (RW + 1)'(HEADER_BYTES - 1)) >> HDR_SH);
                        n_cur   = r_first;
                        n_found = LIST_END;
                        n_state = S_ARD;
                    end else if (i_block_addr[HDR_SH-1:0] != '0
                                 || i_block_addr < AW'(HEADER_BYTES)) begin
                        n_status = ST_BADFREE;
                        n_paddr  = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_u     = UW'(i_block_addr[AW-1:HDR_SH] - 1'b1);
                        n_state = S_FRDU;
                    end
                end
            end
            S_ARD: begin
                n_state = r_cur[UW] ? S_ADEC : S_ACHK;
            end
            S_ACHK: begin
                n_cur   = rdata.next;
                n_state = S_ARD;
                if (fit) begin
                    if (r_fit == FIT_FIRST) begin
                        n_found = r_cur;
                        n_pw    = rdata;
                        n_state = S_ADEC;
                    end else if (r_found[UW] || better) begin
                        n_found = r_cur;
                        n_pw    = rdata;
                    end
                end
            end
            S_ADEC: begin
                if (r_found[UW]) begin
                    n_status = ST_NOFIT;
                    n_paddr  = '0;
                    n_state  = S_DONE;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_WR1;
                    n_dot    = 1'b1;
                    if (LW'(rem) < LW'(TAKE_LIM)) begin
                        // Remainder too small to stand alone: hand out the whole block.
                        n_a1      = r_found[UW-1:0];
                        n_w1      = r_pw;
                        n_w1.used = 1'b1;
                        n_do2     = 1'b0;
                        n_don = 1'b1; n_na = r_pw.prev; n_nv = r_pw.next;
                        n_dop = 1'b1; n_pa = r_pw.next; n_pv = r_pw.prev;
                        n_ta  = LW'(r_found[UW-1:0]) + LW'(r_pw.size) + LW'(1);
                        n_tv  = r_pw.size;
                        out_unit = LW'(r_found[UW-1:0]) + LW'(1);
                    end else begin
                        n_a1  = unit_q;
                        n_w1  = '{used: 1'b1, size: r_need[UW-1:0], lns: rem - UW'(1),
                                  prev: '0, next: '0};
                        n_do2 = 1'b1;
                        n_a2  = r_found[UW-1:0];
                        n_w2      = r_pw;
                        n_w2.size = rem - UW'(1);
                        n_don = 1'b0;
                        n_dop = 1'b0;
                        n_ta  = LW'(unit_q) + r_need + LW'(1);
                        n_tv  = r_need[UW-1:0];
                        out_unit = LW'(unit_q) + LW'(1);
                    end
                    addr_wide = (LW + HDR_SH)'(out_unit) << HDR_SH;
                    n_paddr   = addr_wide[AW-1:0];
                end
            end
            S_FRDU: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (!rdata.used) begin
                    n_status = ST_BADFREE;
                    n_paddr  = '0;
                    n_state  = S_DONE;
                end else begin
                    n_uw    = rdata;
                    n_hasl  = LW'(r_u) >= pl1;
                    n_left  = r_u - rdata.lns - UW'(1);
                    n_r     = alu_sum;
                    n_state = S_FRDL;
                end
            end
            S_FRDL: begin
                n_state = S_FRDR;
            end
            S_FRDR: begin
                n_lw    = rdata;
                n_state = S_FDEC;
            end
            S_FDEC: begin
                n_status  = ST_OK;
                n_paddr   = '0;
                n_state   = S_WR1;
                n_a1      = r_u;
                n_w1      = r_uw;
                n_w1.used = 1'b0;
                n_do2 = 1'b0; n_don = 1'b0; n_dop = 1'b0; n_dot = 1'b0;
                if (!lfree) begin
                    if (!rfree) begin
                        // Lone block goes to the list tail.
                        n_w1.prev = r_last;
                        n_w1.next = LIST_END;
                        n_don = 1'b1; n_na = r_last;   n_nv = LW'(r_u);
                        n_dop = 1'b1; n_pa = LIST_END; n_pv = LW'(r_u);
                    end else begin
                        ns        = r_uw.size + rdata.size + UW'(1);
                        n_w1.size = ns;
                        n_w1.prev = rdata.prev;
                        n_w1.next = rdata.next;
                        n_don = 1'b1; n_na = rdata.prev; n_nv = LW'(r_u);
                        n_dop = 1'b1; n_pa = rdata.next; n_pv = LW'(r_u);
                        n_dot = 1'b1;
                        n_ta  = LW'(r_u) + LW'(ns) + LW'(1);
                        n_tv  = ns;
                    end
                end else begin
                    ns = r_lw.size + r_uw.size + UW'(1);
                    if (rfree) begin
                        ns = ns + rdata.size + UW'(1);
                    end
                    n_do2     = 1'b1;
                    n_a2      = r_left;
                    n_w2      = r_lw;
                    n_w2.size = ns;
                    if (!r_r[UW]) begin
                        n_dot = 1'b1;
                        n_tv  = ns;
                        if (rfree) begin
                            n_don = 1'b1; n_na = rdata.prev; n_nv = rdata.next;
                            n_dop = 1'b1; n_pa = rdata.next; n_pv = rdata.prev;
                            n_ta  = LW'(r_left) + LW'(ns) + LW'(1);
                        end else begin
                            n_ta = r_r;
                        end
                    end
                end
            end
            S_WR1: begin
                n_state = r_do2 ? S_WR2 : S_LN;
            end
            S_WR2: begin
                n_state = S_LN;
            end
            S_LN: begin
                n_state = S_LP;
                if (r_don) begin
                    if (r_na[UW]) begin
                        n_first = r_nv;
                    end else begin
                        n_state = S_LNW;
                    end
                end
            end
            S_LNW: begin
                n_state = S_LP;
            end
            S_LP: begin
                n_state = S_TG;
                if (r_dop) begin
                    if (r_pa[UW]) begin
                        n_last = r_pv;
                    end else begin
                        n_state = S_LPW;
                    end
                end
            end
            S_LPW: begin
                n_state = S_TG;
            end
            S_TG: begin
                n_state = (r_dot && !r_ta[UW]) ? S_TGW : S_DONE;
            end
            S_TGW: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_fit   <= FIT_WORST;
            r_first <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_first <= n_first;
            r_last  <= n_last;
            if (i_cfg_we) begin
                r_fit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need <= n_need;   r_cur <= n_cur;     r_found <= n_found; r_pw <= n_pw;
        r_uw <= n_uw;       r_lw <= n_lw;       r_u <= n_u;         r_left <= n_left;
        r_hasl <= n_hasl;   r_r <= n_r;         r_a1 <= n_a1;       r_a2 <= n_a2;
        r_w1 <= n_w1;       r_w2 <= n_w2;       r_do2 <= n_do2;     r_don <= n_don;
        r_dop <= n_dop;     r_dot <= n_dot;     r_na <= n_na;       r_nv <= n_nv;
        r_pa <= n_pa;       r_pv <= n_pv;       r_ta <= n_ta;       r_tv <= n_tv;
        r_status <= n_status; r_paddr <= n_paddr;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_status       = r_status;
    assign o_payload_addr = r_paddr;

    `BTH_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `BTH_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)
    `BTH_ASSERT_IMP(a_fail_zero_addr, i_clk, i_rst_n, o_valid && o_status != ST_OK,
        o_payload_addr == '0)
    `BTH_ASSERT_IMP(a_list_ends_agree, i_clk, i_rst_n, r_state == S_IDLE,
        r_first[UW] == r_last[UW])
endmodule
